@@ hw/rtl/lru_resident_set_tracker_unit_defines.svh @@
// Assertion macros shared by the LRU resident set tracker RTL.
`ifndef LRU_RESIDENT_SET_TRACKER_UNIT_DEFINES_SVH
`define LRU_RESIDENT_SET_TRACKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold on every rising clock edge outside reset.
`define LRST_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lrst assertion failed");
// Condition must never be seen outside reset.
`define LRST_NEVER(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("lrst forbidden condition seen");
`else
`define LRST_ASSERT(lbl, clk, rst_n, prop)
`define LRST_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

@@ hw/rtl/lrst_pkg.sv @@
// Types and constants shared by the LRU resident set tracker modules.
`timescale 1ns / 1ps

package lrst_pkg;

    localparam int EVENT_KEY_BITS = 32;
    localparam int CAP_BITS       = 7;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_EVICT  = 1'b1;

    // One result word as it leaves the block
    typedef struct packed {
        logic                      kind;
        logic [EVENT_KEY_BITS-1:0] key;
        logic                      last;
    } t_event;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic cmp;        // capture the match flag for the offered key
        logic live;       // cell holds a resident key
        logic load_new;   // take the accessed key (new most-recent slot)
        logic load_prev;  // take the key of the more-recent neighbor
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } t_state;

endpackage

@@ hw/rtl/lrst_cell.sv @@
// One cell of the recency chain: holds a key and its match flag.
`timescale 1ns / 1ps

module lrst_cell
    import lrst_pkg::*;
#(
    parameter int KEY_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [KEY_BITS-1:0] i_cmp_key,
    input  logic [KEY_BITS-1:0] i_new_key,
    input  logic [KEY_BITS-1:0] i_prev_key,
    output logic [KEY_BITS-1:0] o_key,
    output logic                o_match
);

    logic [KEY_BITS-1:0] r_key;
    logic                r_match;

    // Load the accessed key or shift in the neighbor's key
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_new) begin
            r_key <= i_new_key;
        end else if (i_ctl.load_prev) begin
            r_key <= i_prev_key;
        end
    end

    // Capture the compare result when a word is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_match <= i_ctl.live && (r_key == i_cmp_key);
        end
    end

    assign o_key   = r_key;
    assign o_match = r_match;

endmodule

@@ hw/rtl/lrst_suffix.sv @@
// Parallel suffix OR over the cell match flags (Kogge-Stone form).
`timescale 1ns / 1ps

module lrst_suffix #(
    parameter int N = 64
) (
    input  logic [N-1:0] i_flags,
    output logic [N-1:0] o_any_at_or_after
);

    localparam int LEVELS = $clog2(N);

    logic [N-1:0] lvl [LEVELS+1];

    assign lvl[0] = i_flags;

    // Fold in the flag 2^d cells further down at each level
    for (genvar gd = 0; gd < LEVELS; gd++) begin : g_level
        for (genvar gi = 0; gi < N; gi++) begin : g_bit
            if (gi + (1 << gd) < N) begin : g_or
                assign lvl[gd+1][gi] = lvl[gd][gi] | lvl[gd][gi + (1 << gd)];
            end else begin : g_pass
                assign lvl[gd+1][gi] = lvl[gd][gi];
            end
        end
    end

    assign o_any_at_or_after = lvl[LEVELS];

endmodule

@@ hw/rtl/lrst_outq.sv @@
// Two-word result queue in front of the output channel.
`timescale 1ns / 1ps

module lrst_outq
    import lrst_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push0,
    input  t_event                    i_word0,
    input  logic                      i_push1,
    input  t_event                    i_word1,
    output logic [1:0]                o_free,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_event_kind,
    output logic [EVENT_KEY_BITS-1:0] o_event_key,
    output logic                      o_last_of_run
);

    t_event     r_s0, r_s1, n_s0, n_s1;
    logic [1:0] r_cnt, n_cnt;
    logic       w_pop;

    assign w_pop = (r_cnt != 2'd0) && !i_out_stall;

    // Drop the delivered word, then append new words behind what remains
    always_comb begin
        n_s0  = r_s0;
        n_s1  = r_s1;
        n_cnt = r_cnt;
        if (w_pop) begin
            n_s0  = r_s1;
            n_cnt = n_cnt - 2'd1;
        end
        if (i_push0) begin
            if (n_cnt == 2'd0) begin
                n_s0 = i_word0;
            end else begin
                n_s1 = i_word0;
            end
            n_cnt = n_cnt + 2'd1;
        end
        if (i_push1) begin
            n_s1  = i_word1;
            n_cnt = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
        r_s1 <= n_s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Free slots count a word leaving this cycle
    assign o_free        = 2'd2 - r_cnt + {1'b0, w_pop};
    assign o_out_valid   = (r_cnt != 2'd0);
    assign o_event_kind  = r_s0.kind;
    assign o_event_key   = r_s0.key;
    assign o_last_of_run = r_s0.last;

endmodule

@@ hw/rtl/lru_resident_set_tracker_unit.sv @@
// Operation: an accepted access takes a compare pass, then a shift pass through the row of key
// cells that writes its result words into the output queue; on a full miss the evict word comes
// first and the insert word follows it. A new access is taken only after the shift pass of the
// last one; the shift pass waits while the output queue lacks room.
// Reset (synchronous, active low) empties the set and sets capacity to 64; cells keep keys.
// Top level: sequencer and row of recency cells, least recent key in the last cell.
`timescale 1ns / 1ps

module lru_resident_set_tracker_unit
    import lrst_pkg::*;
#(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CAP_BITS-1:0]       i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [EVENT_KEY_BITS-1:0] i_access_key,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_event_kind,
    output logic [EVENT_KEY_BITS-1:0] o_event_key,
    output logic                      o_last_of_run
);

`include "lru_resident_set_tracker_unit_defines.svh"

    localparam int OW   = $clog2(ENTRIES + 1);
    localparam int CW   = (OW > CAP_BITS) ? OW : CAP_BITS;
    localparam int WIDE = (KEY_BITS > EVENT_KEY_BITS) ? KEY_BITS : EVENT_KEY_BITS;

    t_state              r_state;
    logic [OW-1:0]       r_occ;
    logic [CAP_BITS-1:0] r_cap;
    logic [KEY_BITS-1:0] r_key;

    logic [WIDE-1:0]     w_in_wide, w_new_wide, w_tail_wide;
    logic [KEY_BITS-1:0] w_in_key;
    logic [KEY_BITS-1:0] w_cell_key [ENTRIES];
    logic [ENTRIES-1:0]  w_match, w_sfx;
    t_cell_ctl           w_ctl [ENTRIES];

    logic          w_acc, w_upd, w_hit, w_room, w_full_miss;
    logic [OW-1:0] w_mru, w_tgt;
    logic [CW-1:0] w_cap_w, w_eff;
    logic [1:0]    w_free, w_need;
    t_event        w_word0, w_word1;

    // Size the incoming key to the stored width
    assign w_in_wide = WIDE'(i_access_key);
    assign w_in_key  = w_in_wide[KEY_BITS-1:0];

    // Accept only between updates
    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);
    assign w_acc      = i_in_valid && !o_in_stall;

    // Clamp capacity to 1..ENTRIES
    assign w_cap_w = CW'(r_cap);
    always_comb begin
        if (w_cap_w == '0) begin
            w_eff = CW'(1);
        end else if (w_cap_w > CW'(ENTRIES)) begin
            w_eff = CW'(ENTRIES);
        end else begin
            w_eff = w_cap_w;
        end
    end

    // Resident keys sit in cells mru..ENTRIES-1, most recent first
    assign w_mru       = OW'(ENTRIES) - r_occ;
    assign w_hit       = w_sfx[0];
    assign w_room      = CW'(r_occ) < w_eff;
    assign w_full_miss = !w_hit && !w_room;
    assign w_tgt       = (w_hit || !w_room) ? w_mru : (w_mru - OW'(1));
    assign w_need      = w_full_miss ? 2'd2 : 2'd1;
    assign w_upd       = (r_state == S_UPD) && (w_free >= w_need);

    // Drive each cell: compare on accept, shift toward the tail on update
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_ctl[i].cmp       = w_acc;
            w_ctl[i].live      = (OW'(i) >= w_mru);
            w_ctl[i].load_new  = w_upd && (OW'(i) == w_tgt);
            w_ctl[i].load_prev = w_upd && (OW'(i) > w_tgt) && (w_sfx[i] || w_full_miss);
        end
    end

    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
        lrst_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[gi]),
            .i_cmp_key  (w_in_key),
            .i_new_key  (r_key),
            .i_prev_key ((gi == 0) ? r_key : w_cell_key[(gi == 0) ? 0 : gi - 1]),
            .o_key      (w_cell_key[gi]),
            .o_match    (w_match[gi])
        );
    end

    lrst_suffix #(
        .N (ENTRIES)
    ) u_suffix (
        .i_flags           (w_match),
        .o_any_at_or_after (w_sfx)
    );

    // Build result words; evict comes from the fixed tail cell
    assign w_new_wide  = WIDE'(r_key);
    assign w_tail_wide = WIDE'(w_cell_key[ENTRIES-1]);
    always_comb begin
        w_word1.kind = KIND_INSERT;
        w_word1.key  = w_new_wide[EVENT_KEY_BITS-1:0];
        w_word1.last = 1'b1;
        if (w_full_miss) begin
            w_word0.kind = KIND_EVICT;
            w_word0.key  = w_tail_wide[EVENT_KEY_BITS-1:0];
            w_word0.last = 1'b0;
        end else begin
            w_word0 = w_word1;
        end
    end

    lrst_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push0       (w_upd),
        .i_word0       (w_word0),
        .i_push1       (w_upd && w_full_miss),
        .i_word1       (w_word1),
        .o_free        (w_free),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_kind  (o_event_kind),
        .o_event_key   (o_event_key),
        .o_last_of_run (o_last_of_run)
    );

    // Hold the accessed key for the update pass
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_key <= w_in_key;
        end
    end

    // Sequence compare and update, track occupancy and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (w_upd) begin
                        r_state <= S_IDLE;
                        if (!w_hit && w_room) begin
                            r_occ <= r_occ + OW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `LRST_ASSERT(a_occ_bound, i_clk, i_rst_n, r_occ <= OW'(ENTRIES))
    `LRST_ASSERT(a_unique_hit, i_clk, i_rst_n, (r_state == S_UPD) |-> $onehot0(w_match))
    `LRST_ASSERT(a_acc_to_upd, i_clk, i_rst_n, w_acc |=> (r_state == S_UPD))
    `LRST_ASSERT(a_occ_step, i_clk, i_rst_n, (r_occ != $past(r_occ)) |-> (r_occ == $past(r_occ) + OW'(1)))

endmodule

@@ test/lru_resident_set_tracker_checker.sv @@
// Checker for the LRU resident set tracker: recency predictor and result scoreboard.
`timescale 1ns / 1ps

module lru_resident_set_tracker_checker
    import lrst_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CAP_BITS-1:0]       i_cfg_wdata,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [EVENT_KEY_BITS-1:0] i_access_key,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic                      i_event_kind,
    input  logic [EVENT_KEY_BITS-1:0] i_event_key,
    input  logic                      i_last_of_run,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_access_count,
    output int                        o_hit_count,
    output int                        o_evict_count
);

    logic [CAP_BITS-1:0]       capacity_reg;
    // Resident keys, front is most recent, back is least recent
    logic [EVENT_KEY_BITS-1:0] recency_q[$];
    t_event                    event_q[$];
    int                        fails    = 0;
    int                        accesses = 0;
    int                        hits     = 0;
    int                        evicts   = 0;

    // Clamp the register to 1..ENTRIES
    function automatic int effective_capacity();
        int c;
        c = int'(capacity_reg);
        if (c < 1) begin
            c = 1;
        end
        if (c > ENTRIES) begin
            c = ENTRIES;
        end
        return c;
    endfunction

    // Update recency order for one access and queue the words it causes
    task automatic track_access(input logic [EVENT_KEY_BITS-1:0] key);
        int     hit_pos;
        t_event ev;
        hit_pos = -1;
        foreach (recency_q[i]) begin
            if (recency_q[i] == key) begin
                hit_pos = i;
            end
        end
        if (hit_pos >= 0) begin
            recency_q.delete(hit_pos);
            hits++;
        end else if (recency_q.size() >= effective_capacity()) begin
            // Set full (or capacity lowered under occupancy): drop the least recent
            ev.kind = KIND_EVICT;
            ev.key  = recency_q[$];
            ev.last = 1'b0;
            event_q.insert(event_q.size(), ev);
            void'(recency_q.pop_back());
            evicts++;
        end
        recency_q.push_front(key);
        ev.kind = KIND_INSERT;
        ev.key  = key;
        ev.last = 1'b1;
        event_q.insert(event_q.size(), ev);
    endtask

    // Compare one delivered word against the oldest expectation
    task automatic check_word();
        t_event exp_ev;
        if (event_q.size() == 0) begin
            $display("%0t: unexpected word: expected none, got kind=%0d key=%h last=%0d",
                     $time, i_event_kind, i_event_key, i_last_of_run);
            fails++;
        end else begin
            exp_ev = event_q[0];
            event_q.delete(0);
            if (i_event_kind !== exp_ev.kind) begin
                $display("%0t: event_kind mismatch: expected %0d, got %0d",
                         $time, exp_ev.kind, i_event_kind);
                fails++;
            end
            if (i_event_key !== exp_ev.key) begin
                $display("%0t: event_key mismatch: expected %h, got %h",
                         $time, exp_ev.key, i_event_key);
                fails++;
            end
            if (i_last_of_run !== exp_ev.last) begin
                $display("%0t: last_of_run mismatch: expected %0d, got %0d",
                         $time, exp_ev.last, i_last_of_run);
                fails++;
            end
        end
    endtask

    // Watch config, input and output channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity_reg = CAP_RESET;
            recency_q.delete();
            event_q.delete();
        end else begin
            if (i_cfg_we) begin
                capacity_reg = i_cfg_wdata;
            end
            if (i_in_valid && !i_in_stall) begin
                track_access(i_access_key);
                accesses++;
            end
            if (i_out_valid && !i_out_stall) begin
                check_word();
            end
        end
        o_fail_count   <= fails;
        o_pending      <= event_q.size();
        o_access_count <= accesses;
        o_hit_count    <= hits;
        o_evict_count  <= evicts;
    end

endmodule

@@ test/tb_lru_resident_set_tracker_unit.sv @@
// Testbench top for the LRU resident set tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_lru_resident_set_tracker_unit
    import lrst_pkg::*;
();

    localparam int ENTRIES      = 64;
    localparam int RESET_CYCLES = 11;
    localparam int MAX_GAP      = 13;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CAP_BITS-1:0]       i_cfg_wdata;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [EVENT_KEY_BITS-1:0] i_access_key;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic                      o_event_kind;
    logic [EVENT_KEY_BITS-1:0] o_event_key;
    logic                      o_last_of_run;

    int fail_count;
    int pending;
    int access_count;
    int hit_count;
    int evict_count;
    int cycle_count = 0;
    bit tx_idle     = 1'b0;
    bit rx_idle     = 1'b0;
    int rx_hold     = 0;

    always #4 i_clk = ~i_clk;

    lru_resident_set_tracker_unit #(
        .ENTRIES (ENTRIES),
        .KEY_BITS(EVENT_KEY_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_access_key (i_access_key),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_kind (o_event_kind),
        .o_event_key  (o_event_key),
        .o_last_of_run(o_last_of_run)
    );

    lru_resident_set_tracker_checker #(
        .ENTRIES(ENTRIES)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_access_key  (i_access_key),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_event_kind  (o_event_kind),
        .i_event_key   (o_event_key),
        .i_last_of_run (o_last_of_run),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_access_count(access_count),
        .o_hit_count   (hit_count),
        .o_evict_count (evict_count)
    );

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stall before each word when enabled, plus an optional long hold-off
    initial begin
        int wait_cycles;
        i_out_stall = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            wait_cycles = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (rx_hold > 0) begin
                wait_cycles = wait_cycles + rx_hold;
                rx_hold = 0;
            end
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!(o_out_valid && !i_out_stall)) @(posedge i_clk);
        end
    end

    // Offer one access word and hold it until taken
    task automatic send_key(input logic [EVENT_KEY_BITS-1:0] key);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_access_key <= key;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait until every expected word has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random accesses drawn mostly from a working set of pool_size keys
    task automatic run_phase(input logic [CAP_BITS-1:0] cap, input int n_items,
                             input int pool_size, input bit tx_on, input bit rx_on,
                             input int hold);
        logic [EVENT_KEY_BITS-1:0] pool[];
        int                        pick;
        write_capacity(cap);
        pool = new[pool_size];
        foreach (pool[i]) begin
            pool[i] = $urandom;
        end
        tx_idle = tx_on;
        rx_idle = rx_on;
        rx_hold = hold;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                send_key(pool[$urandom_range(0, pool_size - 1)]);
            end else if (pick < 90) begin
                send_key(pool[0]);
            end else begin
                send_key($urandom);
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_access_key = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single-entry set, key extremes, hit then evict
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_capacity(7'd1);
        send_key(32'h0000_0000);
        send_key(32'h0000_0000);
        send_key(32'hFFFF_FFFF);
        send_key(32'hFFFF_FFFF);
        send_key(32'h0000_0000);
        // Directed: capacity zero behaves as one
        write_capacity(7'd0);
        send_key(32'h5555_AAAA);
        send_key(32'hAAAA_5555);
        send_key(32'hAAAA_5555);
        send_key(32'h8000_0001);

        // Random phases: growing capacity, then lowered under occupancy, then saturated and lowered again
        run_phase(7'd2,   80,  4,  1'b1, 1'b1, 0);
        run_phase(7'd3,   80,  5,  1'b0, 1'b0, 0);
        run_phase(7'd7,   100, 10, 1'b1, 1'b1, 0);
        run_phase(7'd16,  120, 22, 1'b0, 1'b1, HOLD_CYCLES);
        run_phase(7'd33,  140, 45, 1'b1, 1'b0, 0);
        run_phase(7'd5,   100, 40, 1'b1, 1'b1, 0);
        run_phase(7'd127, 160, 80, 1'b1, 1'b1, 0);
        run_phase(7'd100, 100, 75, 1'b0, 1'b1, 0);
        run_phase(7'd64,  150, 70, 1'b1, 1'b1, 0);
        run_phase(7'd0,   100, 70, 1'b1, 1'b0, 0);
        run_phase(7'd48,  170, 66, 1'b1, 1'b1, 0);

        repeat (10) @(posedge i_clk);
        $display("Run covered %0d accesses: %0d hits, %0d evictions,", access_count,
                 hit_count, evict_count);
        $display("capacities 0, 1, 2, 3, 5, 7, 16, 33, 48, 64, 100, 127 incl. lowered set");
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
